// ===== hw/rtl/e2esw_pkg.sv =====
package e2esw_pkg;

   // Default window capacity for the top-level parameter.
   localparam int WINDOW_MAX_DEF = 32;

   // Window counters saturate at all ones.
   localparam int COUNT_W = 6;
   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   // Configuration register widths and indexes.
   localparam int CSR_W     = 8;
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_SIZE     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_OK_INIT     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_ERROR_VALID = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_OK_INVALID  = 2'd3;

   // Configuration reset values.
   localparam logic [CSR_W-1:0] WINDOW_SIZE_RST     = 8'd8;
   localparam logic [CSR_W-1:0] MIN_OK_INIT_RST     = 8'd1;
   localparam logic [CSR_W-1:0] MAX_ERROR_VALID_RST = 8'd0;
   localparam logic [CSR_W-1:0] MIN_OK_INVALID_RST  = 8'd1;

   // Input command codes.
   localparam logic CMD_CHECK  = 1'b0;
   localparam logic CMD_REINIT = 1'b1;

   // Status codes of the state machine.
   localparam int MODE_W = 2;
   localparam logic [MODE_W-1:0] MODE_INIT    = 2'd0;
   localparam logic [MODE_W-1:0] MODE_VALID   = 2'd1;
   localparam logic [MODE_W-1:0] MODE_INVALID = 2'd2;

   // Operations handed from the front end to the back end.
   localparam int OP_W = 2;
   localparam logic [OP_W-1:0] OP_CHECK  = 2'd0;
   localparam logic [OP_W-1:0] OP_REINIT = 2'd1;
   localparam logic [OP_W-1:0] OP_ZERO   = 2'd2;

   // Classified operation without the window size.
   typedef struct packed {
      logic [OP_W-1:0] op;
      logic            profile_ok;
   } e2esw_op_type;

   // State machine thresholds from the configuration registers.
   typedef struct packed {
      logic [CSR_W-1:0] min_ok_init;
      logic [CSR_W-1:0] max_error_valid;
      logic [CSR_W-1:0] min_ok_invalid;
   } e2esw_thresh_type;

endpackage

// ===== hw/rtl/e2e_sliding_window_state_machine.sv =====
// Sliding-window end-to-end check state machine. Each accepted beat is either a
// reinitialize command or one message check result, and each produces exactly one
// status beat (INIT, VALID or INVALID) in order. The block sustains one beat per
// clock cycle on both sides while the result queue is drained and neither queue is full.
// An accepted request is registered in the queue between the front and back ends;
// the back end then takes it and writes its status beat into the result queue.
// The back end updates the window and state and writes the result queue in the
// same cycle. Both internal queues hold two beats, so either side may stall without
// stopping the other at once. The user must see that configuration registers are
// written through the csr port while the block is idle; it does not enforce this.
module e2e_sliding_window_state_machine #(
   parameter int WINDOW_MAX = e2esw_pkg::WINDOW_MAX_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_push,
   output logic                              req_full,
   input  logic                              req_cmd,
   input  logic                              req_profile_ok,
   output logic                              rsp_empty,
   input  logic                              rsp_pop,
   output logic [e2esw_pkg::MODE_W-1:0]      rsp_sm_status,
   input  logic                              csr_write_en,
   input  logic [e2esw_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [e2esw_pkg::CSR_W-1:0]       csr_wdata
);
   import e2esw_pkg::*;

   localparam int SIZE_W = $clog2(WINDOW_MAX + 1);
   localparam int ITEM_W = OP_W + 1 + SIZE_W;
   localparam int QUEUE_DEPTH = 2;

   logic [ITEM_W-1:0] front_item;
   logic [ITEM_W-1:0] back_item;
   logic              mid_full;
   logic              mid_empty;
   logic              mid_pop;
   logic              out_full;
   logic              out_push;
   logic [MODE_W-1:0] out_status;
   e2esw_thresh_type  thresh;

   assign req_full = mid_full;

   // Front end: configuration registers and beat classification.
   e2esw_front #(
      .WINDOW_MAX (WINDOW_MAX)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_cmd        (req_cmd),
      .req_profile_ok (req_profile_ok),
      .item           (front_item),
      .thresh         (thresh)
   );

   // Queue between the front and back ends.
   e2esw_fifo #(
      .WIDTH (ITEM_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_mid_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push),
      .push_data (front_item),
      .full      (mid_full),
      .pop       (mid_pop),
      .empty     (mid_empty),
      .pop_data  (back_item)
   );

   // Back end: window, counters and state machine.
   e2esw_back #(
      .WINDOW_MAX (WINDOW_MAX)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .item_empty (mid_empty),
      .item       (back_item),
      .item_pop   (mid_pop),
      .thresh     (thresh),
      .rsp_full   (out_full),
      .rsp_push   (out_push),
      .rsp_status (out_status)
   );

   // Result queue toward the consumer.
   e2esw_fifo #(
      .WIDTH (MODE_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (out_push),
      .push_data (out_status),
      .full      (out_full),
      .pop       (rsp_pop),
      .empty     (rsp_empty),
      .pop_data  (rsp_sm_status)
   );

endmodule

// ===== hw/rtl/e2esw_fifo.sv =====
module e2esw_fifo #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic             empty,
   output logic [WIDTH-1:0] pop_data
);
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign full     = (count_ff == FULL_CNT);
   assign empty    = (count_ff == '0);
   assign pop_data = mem_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage carries payload only.
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== hw/rtl/e2esw_front.sv =====
module e2esw_front #(
   parameter int WINDOW_MAX = e2esw_pkg::WINDOW_MAX_DEF,
   localparam int SIZE_W = $clog2(WINDOW_MAX + 1),
   localparam int ITEM_W = e2esw_pkg::OP_W + 1 + SIZE_W
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write_en,
   input  logic [e2esw_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [e2esw_pkg::CSR_W-1:0]          csr_wdata,
   input  logic                                 req_cmd,
   input  logic                                 req_profile_ok,
   output logic [ITEM_W-1:0]                    item,
   output e2esw_pkg::e2esw_thresh_type          thresh
);
   import e2esw_pkg::*;

   localparam logic [CSR_W-1:0] SIZE_LIMIT = CSR_W'(WINDOW_MAX);

   logic [CSR_W-1:0] window_size_ff;
   logic [CSR_W-1:0] min_ok_init_ff;
   logic [CSR_W-1:0] max_error_valid_ff;
   logic [CSR_W-1:0] min_ok_invalid_ff;
   logic [SIZE_W-1:0] size_clamped;
   e2esw_op_type      op_item;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         window_size_ff     <= WINDOW_SIZE_RST;
         min_ok_init_ff     <= MIN_OK_INIT_RST;
         max_error_valid_ff <= MAX_ERROR_VALID_RST;
         min_ok_invalid_ff  <= MIN_OK_INVALID_RST;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_WINDOW_SIZE:     window_size_ff     <= csr_wdata;
            CSR_MIN_OK_INIT:     min_ok_init_ff     <= csr_wdata;
            CSR_MAX_ERROR_VALID: max_error_valid_ff <= csr_wdata;
            CSR_MIN_OK_INVALID:  min_ok_invalid_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign thresh.min_ok_init     = min_ok_init_ff;
   assign thresh.max_error_valid = max_error_valid_ff;
   assign thresh.min_ok_invalid  = min_ok_invalid_ff;

   // Clamp the window length to the storage capacity.
   assign size_clamped = (window_size_ff > SIZE_LIMIT) ? SIZE_W'(WINDOW_MAX)
                                                       : SIZE_W'(window_size_ff);

   // Classify the beat: reinitialize, check on an empty window, or real check.
   always_comb begin
      op_item.profile_ok = req_profile_ok;
      if (req_cmd == CMD_REINIT) begin
         op_item.op = OP_REINIT;
      end else if (window_size_ff == '0) begin
         op_item.op = OP_ZERO;
      end else begin
         op_item.op = OP_CHECK;
      end
   end

   assign item = {op_item, size_clamped};

endmodule

// ===== hw/rtl/e2esw_back.sv =====
module e2esw_back #(
   parameter int WINDOW_MAX = e2esw_pkg::WINDOW_MAX_DEF,
   localparam int SIZE_W = $clog2(WINDOW_MAX + 1),
   localparam int ITEM_W = e2esw_pkg::OP_W + 1 + SIZE_W
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              item_empty,
   input  logic [ITEM_W-1:0]                 item,
   output logic                              item_pop,
   input  e2esw_pkg::e2esw_thresh_type       thresh,
   input  logic                              rsp_full,
   output logic                              rsp_push,
   output logic [e2esw_pkg::MODE_W-1:0]      rsp_status
);
   import e2esw_pkg::*;

   localparam int POS_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;

   e2esw_op_type      op_item;
   logic [SIZE_W-1:0] size;
   logic              fire;

   logic [WINDOW_MAX-1:0] window_ff, window_in;
   logic [COUNT_W-1:0]    ok_total_ff, ok_total_in;
   logic [COUNT_W-1:0]    error_total_ff, error_total_in;
   logic [SIZE_W-1:0]     filled_ff, filled_in;
   logic [POS_W-1:0]      write_pos_ff, write_pos_in;
   logic [MODE_W-1:0]     mode_ff, mode_in;

   logic [COUNT_W-1:0] ok_evict;
   logic [COUNT_W-1:0] error_evict;
   logic [SIZE_W-1:0]  pos_next;
   logic               entry_err;

   assign {op_item, size} = item;
   assign fire     = !item_empty && !rsp_full;
   assign item_pop = fire;
   assign rsp_push = fire;

   // One beat per cycle if not stalled: evict, insert, advance, step FSM.
   always_comb begin
      window_in      = window_ff;
      ok_total_in    = ok_total_ff;
      error_total_in = error_total_ff;
      filled_in      = filled_ff;
      write_pos_in   = write_pos_ff;
      mode_in        = mode_ff;
      rsp_status     = MODE_INVALID;
      entry_err      = !op_item.profile_ok;
      ok_evict       = ok_total_ff;
      error_evict    = error_total_ff;
      pos_next       = SIZE_W'(write_pos_ff) + 1'b1;

      unique case (op_item.op)
         OP_REINIT: begin
            window_in      = '1;
            ok_total_in    = '0;
            error_total_in = '0;
            filled_in      = '0;
            write_pos_in   = '0;
            mode_in        = MODE_INIT;
            rsp_status     = MODE_INIT;
         end
         OP_CHECK: begin
            // Drop the oldest entry once the window is full.
            if (filled_ff >= size) begin
               if (!window_ff[write_pos_ff]) begin
                  if (ok_total_ff != '0) ok_evict = ok_total_ff - 1'b1;
               end else begin
                  if (error_total_ff != '0) error_evict = error_total_ff - 1'b1;
               end
            end else begin
               filled_in = filled_ff + 1'b1;
            end

            // Insert the new entry with saturating counts.
            window_in[write_pos_ff] = entry_err;
            ok_total_in    = ok_evict;
            error_total_in = error_evict;
            if (!entry_err) begin
               if (ok_evict != COUNT_MAX) ok_total_in = ok_evict + 1'b1;
            end else begin
               if (error_evict != COUNT_MAX) error_total_in = error_evict + 1'b1;
            end

            write_pos_in = (pos_next >= size) ? '0 : POS_W'(pos_next);

            // Threshold state machine on the updated counts.
            unique case (mode_ff)
               MODE_INIT: begin
                  if (CSR_W'(ok_total_in) >= thresh.min_ok_init) mode_in = MODE_VALID;
               end
               MODE_VALID: begin
                  if (CSR_W'(error_total_in) > thresh.max_error_valid) begin
                     mode_in = MODE_INVALID;
                  end
               end
               MODE_INVALID: begin
                  if (CSR_W'(ok_total_in) >= thresh.min_ok_invalid) mode_in = MODE_VALID;
               end
               default: mode_in = MODE_INVALID;
            endcase
            rsp_status = mode_in;
         end
         default: begin
            // Zero-length window reports invalid and leaves the state alone.
            rsp_status = MODE_INVALID;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff      <= '1;
         ok_total_ff    <= '0;
         error_total_ff <= '0;
         filled_ff      <= '0;
         write_pos_ff   <= '0;
         mode_ff        <= MODE_INIT;
      end else if (fire) begin
         window_ff      <= window_in;
         ok_total_ff    <= ok_total_in;
         error_total_ff <= error_total_in;
         filled_ff      <= filled_in;
         write_pos_ff   <= write_pos_in;
         mode_ff        <= mode_in;
      end
   end

endmodule
